[rtl/sorted_trimmed_mean_filter_core_defines.svh]
// ----------------------------------------------------------------------------
// Sorted trimmed mean filter - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TRIMMED_MEAN_FILTER_CORE_DEFINES_SVH
`define SORTED_TRIMMED_MEAN_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define STMF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STMF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STMF_ASSERT(label, clk, rst_n, prop, msg)
`define STMF_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/stmf_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted trimmed mean filter - package
// Sizes, list constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package stmf_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned LIST_LEN = 6;
  localparam int unsigned KEEP_LEN = 2;
  localparam int unsigned MID_HI   = 3;

  localparam int unsigned CH_W   = 2;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned DEPTH  = CHANNELS * LIST_LEN;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [CNT_W-1:0] CNT_KEEP = CNT_W'(KEEP_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIST_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_LEN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_PLACE,
    ST_MID_A,
    ST_MID_B,
    ST_MID_C,
    ST_MID_D,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/sorted_trimmed_mean_filter_core.sv]
// ----------------------------------------------------------------------------
// Sorted trimmed mean filter core
// Per-channel insertion sort of samples; every fourth sample of a channel
// sets the held output to the mean of the two middle list values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = channel, tdata = 16-bit unsigned sample.
//   Master stream: one result per request; tdata = held filtered value,
//   tuser = {updated, channel}.
//   The six-entry lists of all channels sit in one 1R1W synchronous RAM.
//   Insertion walks down the list one entry per cycle (read of the next
//   entry overlaps the shift write). A request that closes a batch also
//   reads the middle pair from the RAM and writes it back as the first
//   two entries of the list.
//   One request is in work at a time; the next one is taken as soon as the
//   result sits in the output register, even if the receiver stalls.
//   A stalled receiver holds the result; the core then waits in its final
//   step until the output register frees.
//   Reset empties all lists (entries read as zero via per-entry valid bits),
//   sets each channel's fill count to two and its held value to zero. No
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_trimmed_mean_filter_core_defines.svh"

module sorted_trimmed_mean_filter_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [stmf_pkg::SMP_W-1:0] s_axis_tdata,   // [15:0] sample
  input  wire  [stmf_pkg::CH_W-1:0]  s_axis_tuser,   // [1:0] channel
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [stmf_pkg::SMP_W-1:0] m_axis_tdata,   // [15:0] filtered
  output logic [stmf_pkg::CH_W:0]    m_axis_tuser    // [1:0] out_channel, [2] updated
);
  import stmf_pkg::*;

  state_e state_q, state_d;

  logic [CH_W-1:0]  ch_q;
  logic             ch_ok_q;
  logic [SMP_W-1:0] smp_q;
  logic [AW-1:0]    base_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q;
  logic [SMP_W-1:0] lo_q, hi_q;
  logic             upd_q;

  logic [CNT_W-1:0] fill_q [CHANNELS];
  logic [SMP_W-1:0] held_q [CHANNELS];

  logic [SMP_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [SMP_W-1:0] rd_data_q;
  logic             rd_vld_q;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [SMP_W-1:0] mem_wdata;
  logic             fill_we, held_we, lo_we, hi_we, upd_set, out_load;

  logic             in_acc;
  logic [CIDX_W-1:0] in_idx, ch_idx;
  logic [CNT_W-1:0] fill_rd, cnt_in;
  logic             ch_ok_in;
  logic [SMP_W-1:0] rdat;
  logic             lt;
  logic             batch;
  logic [SMP_W:0]   sum;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_idx   = CIDX_W'(s_axis_tuser);
  assign ch_idx   = CIDX_W'(ch_q);
  assign ch_ok_in = 32'(s_axis_tuser) < CHANNELS;
  assign fill_rd  = fill_q[in_idx];
  assign cnt_in   = (fill_rd < CNT_KEEP || fill_rd >= CNT_FULL) ? CNT_KEEP : fill_rd;
  assign rdat     = rd_vld_q ? rd_data_q : '0;
  assign lt       = smp_q < rdat;
  assign batch    = cnt_q == CNT_LAST;
  assign sum      = {1'b0, lo_q} + {1'b0, rdat};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ch_ok_in ? ST_RD : ST_DONE;
        end
      end
      ST_RD:    state_d = ST_CMP;
      ST_CMP: begin
        if (lt) begin
          if (pos_q == POS_W'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = batch ? ST_MID_A : ST_DONE;
        end
      end
      ST_PLACE: state_d = batch ? ST_MID_A : ST_DONE;
      ST_MID_A: state_d = ST_MID_B;
      ST_MID_B: state_d = ST_MID_C;
      ST_MID_C: state_d = ST_MID_D;
      ST_MID_D: state_d = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = base_q + AW'(pos_q);
    mem_wdata = smp_q;
    mem_raddr = base_q + AW'(pos_q - POS_W'(1));
    pos_d     = pos_q;
    fill_we   = 1'b0;
    held_we   = 1'b0;
    lo_we     = 1'b0;
    hi_we     = 1'b0;
    upd_set   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (lt) begin
          mem_wdata = rdat;
          pos_d     = pos_q - POS_W'(1);
          if (pos_q != POS_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = base_q + AW'(pos_q - POS_W'(2));
          end
        end else begin
          fill_we = 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = base_q;
        fill_we   = 1'b1;
      end
      ST_MID_A: begin
        mem_re    = 1'b1;
        mem_raddr = base_q + AW'(KEEP_LEN);
      end
      ST_MID_B: begin
        mem_re    = 1'b1;
        mem_raddr = base_q + AW'(MID_HI);
        lo_we     = 1'b1;
      end
      ST_MID_C: begin
        mem_we    = 1'b1;
        mem_waddr = base_q;
        mem_wdata = lo_q;
        hi_we     = 1'b1;
        held_we   = 1'b1;
      end
      ST_MID_D: begin
        mem_we    = 1'b1;
        mem_waddr = base_q + AW'(1);
        mem_wdata = hi_q;
        upd_set   = 1'b1;
      end
      ST_DONE: begin
        out_load = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upd_q   <= 1'b0;
      ch_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        upd_q   <= 1'b0;
        ch_ok_q <= ch_ok_in;
      end else if (upd_set) begin
        upd_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= s_axis_tuser;
      smp_q  <= s_axis_tdata;
      base_q <= AW'(s_axis_tuser) * AW'(LIST_LEN);
      cnt_q  <= cnt_in;
      pos_q  <= POS_W'(cnt_in);
    end else begin
      pos_q <= pos_d;
    end
    if (lo_we) begin
      lo_q <= rdat;
    end
    if (hi_we) begin
      hi_q <= rdat;
    end
  end

  // per-channel fill counts and held outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        fill_q[i] <= CNT_KEEP;
        held_q[i] <= '0;
      end
    end else begin
      if (fill_we) begin
        fill_q[ch_idx] <= batch ? CNT_KEEP : cnt_q + CNT_W'(1);
      end
      if (held_we) begin
        held_q[ch_idx] <= sum[SMP_W:1];
      end
    end
  end

  // list RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[mem_raddr];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= ch_ok_q ? held_q[ch_idx] : '0;
      m_axis_tuser <= {upd_q, ch_q};
    end
  end

  `STMF_ASSERT_NEVER(a_rw_same_entry, clk_i, rst_ni, mem_we && mem_re && (mem_waddr == mem_raddr), "list RAM read and write hit the same entry")
  `STMF_ASSERT(a_pos_range, clk_i, rst_ni, (state_q == ST_CMP) |-> (pos_q >= POS_W'(1) && pos_q <= POS_W'(cnt_q)), "insertion position out of range")
  `STMF_ASSERT(a_fill_range, clk_i, rst_ni, in_acc |-> (fill_rd >= CNT_KEEP && fill_rd < CNT_FULL), "fill count out of range")
  `STMF_ASSERT(a_upd_batch, clk_i, rst_ni, (out_load && upd_q) |-> batch, "update flagged without a full batch")

endmodule

`default_nettype wire
